FILE: rtl/core/ibd_pkg.sv
// Shared types and constants for the invert and 2x2 box downsample block.
`timescale 1ns / 1ps
`default_nettype none

package ibd_pkg;

    // Pixel layout: four 8-bit channels, red in the lowest byte.
    localparam int CHAN_W    = 8;
    localparam int NUM_CHAN  = 4;
    localparam int PIXEL_W   = CHAN_W * NUM_CHAN;
    localparam int LANE_W    = CHAN_W + 1;
    localparam int RGB_CHANS = 3;

    // Frame height limit and its counter width.
    localparam int MAX_HEIGHT = 4096;
    localparam int ROW_W      = 12;

    // Configuration port.
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_INVERT_ENABLE = 2'd2;

    localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    // Arithmetic constants.
    localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'hFF;
    localparam logic [1:0]        ROUND_BIAS = 2'd2;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [NUM_CHAN-1:0][LANE_W-1:0] pair_t;

endpackage

`default_nettype wire

FILE: rtl/core/invert_and_box_downsample_2x2.sv
// Top level of the RGBA invert and 2x2 box-filter downsampler.
`timescale 1ns / 1ps
`default_nettype none

// This block takes RGBA pixels in raster order, one beat per pixel, and gives one
// output pixel for every complete 2x2 block, so the output frame is floor(width/2)
// by floor(height/2); a trailing odd column or odd row is dropped. When
// invert_enable is set, red, green and blue are replaced by 255 minus their value
// before averaging, and alpha is never inverted. Each channel of an output pixel is
// (sum of the four inputs + 2) / 4. The beat carrying the last output pixel of a
// frame has tlast set, after which the row and column counters start a new frame.
// The block takes one input pixel per clock unless the input side stalls: a pixel
// is worked on in the first stage as it is accepted, its flags and line data are
// registered in the second stage, and a completing pixel's result is loaded into the
// output register when the second stage advances. Horizontal pair sums
// of even rows are held in a line buffer of MAX_WIDTH/2 entries of 36 bits with one
// write and one registered read per cycle, and that buffer port is what limits the
// rate to one pixel a clock. The input side stalls only while the output register
// holds a result that the sink has not taken and the stage behind it is full.
// Configuration registers (index 0 frame_width, 1 frame_height, 2 invert_enable)
// are written through the cfg port, which is always ready; they should be written
// only while no pixel is in flight. A width of 0 acts as 1 and a width above
// MAX_WIDTH acts as MAX_WIDTH; the same holds for height with a limit of 4096.
module invert_and_box_downsample_2x2 #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    // Input pixel stream.
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata fields from bit 0: in_red, in_green, in_blue, in_alpha.
    input  wire logic [ibd_pkg::PIXEL_W-1:0]       s_axis_tdata,

    // Output pixel stream.
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // tdata fields from bit 0: out_red, out_green, out_blue, out_alpha.
    output logic [ibd_pkg::PIXEL_W-1:0]            m_axis_tdata,
    // frame_done: set on the last output pixel of the frame.
    output logic                                   m_axis_tlast,

    // Configuration write channel.
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ibd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [ibd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import ibd_pkg::*;

    // Column counter bits, bits of an effective width (which may equal MAX_WIDTH),
    // width used to compare a register value with MAX_WIDTH, and line buffer sizing.
    localparam int COL_W      = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int EFF_W      = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W      = (EFF_W > CFG_DATA_W) ? EFF_W : CFG_DATA_W;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int SLOT_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int HGT_W      = ROW_W + 1;
    localparam int ACC_W      = LANE_W + 2;

    // Configuration registers.
    logic [CFG_DATA_W-1:0] frame_width_reg;
    logic [CFG_DATA_W-1:0] frame_height_reg;
    logic                  invert_enable_reg;

    // Frame position of the next input pixel.
    logic [COL_W-1:0]      column_reg;
    logic [COL_W-1:0]      column_next;
    logic [ROW_W-1:0]      row_reg;
    logic [ROW_W-1:0]      row_next;

    // Running horizontal pair sum; it also serves as the pair operand of the
    // item held in the second stage, since it only changes on an accept.
    pair_t                 pair_sum_reg;
    pair_t                 pair_sum_next;

    // Line buffer and its registered read port.
    pair_t                 line_mem [LINE_DEPTH];
    pair_t                 line_rd_reg;

    // Second stage: one item whose line data is being read.
    logic                  stage_valid_reg;
    logic                  stage_valid_next;
    logic                  stage_emit_reg;
    logic                  stage_last_reg;

    // Output register.
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [PIXEL_W-1:0]    out_data_reg;
    logic [PIXEL_W-1:0]    out_data_next;
    logic                  out_last_reg;

    logic                  in_beat;
    logic                  advance;
    logic                  out_load;

    logic [EFF_W-1:0]      width_eff;
    logic [HGT_W-1:0]      height_eff;
    logic [EFF_W-1:0]      column_plus;
    logic [HGT_W-1:0]      row_plus;
    logic [SLOT_W-1:0]     slot;
    logic                  col_odd;
    logic                  row_odd;
    logic                  line_write;
    logic                  emit_now;
    logic                  last_now;
    pair_t                 pixel_lanes;

    // ------------------------------------------------------------------
    // Handshakes. The second stage frees when the output register can take
    // its item; an empty second stage still takes a pixel while a result waits.
    // ------------------------------------------------------------------
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !stage_valid_reg || advance;
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_load      = advance && stage_valid_reg && stage_emit_reg;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // ------------------------------------------------------------------
    // Configuration writes. Indexes beyond the register list are ignored.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg   <= FRAME_WIDTH_RST;
            frame_height_reg  <= FRAME_HEIGHT_RST;
            invert_enable_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:   frame_width_reg   <= cfg_data;
                REG_FRAME_HEIGHT:  frame_height_reg  <= cfg_data;
                REG_INVERT_ENABLE: invert_enable_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Effective frame size after clamping to the supported range.
    // ------------------------------------------------------------------
    always_comb
    begin
        if (frame_width_reg == '0)
            width_eff = EFF_W'(1);
        else if (CMP_W'(frame_width_reg) > CMP_W'(MAX_WIDTH))
            width_eff = EFF_W'(MAX_WIDTH);
        else
            width_eff = EFF_W'(frame_width_reg);

        if (frame_height_reg == '0)
            height_eff = HGT_W'(1);
        else if (frame_height_reg > CFG_DATA_W'(MAX_HEIGHT))
            height_eff = HGT_W'(MAX_HEIGHT);
        else
            height_eff = HGT_W'(frame_height_reg);
    end

    // ------------------------------------------------------------------
    // First stage: invert, pair sum, line buffer address and flags.
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            if ((c < RGB_CHANS) && invert_enable_reg)
                pixel_lanes[c] = LANE_W'(CHAN_MAX - s_axis_tdata[c*CHAN_W +: CHAN_W]);
            else
                pixel_lanes[c] = LANE_W'(s_axis_tdata[c*CHAN_W +: CHAN_W]);
        end
    end

    assign col_odd = column_reg[0];
    assign row_odd = row_reg[0];
    assign slot    = SLOT_W'(column_reg >> 1);

    always_comb
    begin
        pair_sum_next = pair_sum_reg;
        if (in_beat)
        begin
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                if (col_odd)
                    pair_sum_next[c] = pair_sum_reg[c] + pixel_lanes[c];
                else
                    pair_sum_next[c] = pixel_lanes[c];
            end
        end
    end

    assign line_write = in_beat && col_odd && !row_odd;
    assign emit_now   = col_odd && row_odd;

    // The last block of a frame ends one below the width and height rounded down to even.
    assign last_now = ((EFF_W'(column_reg) + EFF_W'(1)) == {width_eff[EFF_W-1:1], 1'b0})
                   && ((HGT_W'(row_reg) + HGT_W'(1)) == {height_eff[HGT_W-1:1], 1'b0});

    // Position update. A count that reaches or passes the size wraps.
    assign column_plus = EFF_W'(column_reg) + EFF_W'(1);
    assign row_plus    = HGT_W'(row_reg) + HGT_W'(1);

    always_comb
    begin
        column_next = column_reg;
        row_next    = row_reg;
        if (in_beat)
        begin
            if (column_plus >= width_eff)
            begin
                column_next = '0;
                if (row_plus >= height_eff)
                    row_next = '0;
                else
                    row_next = row_plus[ROW_W-1:0];
            end
            else
            begin
                column_next = column_plus[COL_W-1:0];
            end
        end
    end

    // Line buffer: written on even rows, read on every accept so the data
    // lines up with the item entering the second stage.
    always_ff @(posedge clk)
    begin
        if (line_write)
            line_mem[slot] <= pair_sum_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
            line_rd_reg <= line_mem[slot];
    end

    // ------------------------------------------------------------------
    // Second stage: block average into the output register.
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [ACC_W-1:0] acc;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            acc = ACC_W'(line_rd_reg[c]) + ACC_W'(pair_sum_reg[c]) + ACC_W'(ROUND_BIAS);
            out_data_next[c*CHAN_W +: CHAN_W] = acc[CHAN_W+1:2];
        end
    end

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (in_beat)
            stage_valid_next = 1'b1;
        else if (advance)
            stage_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = stage_valid_reg && stage_emit_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg      <= '0;
            row_reg         <= '0;
            pair_sum_reg    <= '0;
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            column_reg      <= column_next;
            row_reg         <= row_next;
            pair_sum_reg    <= pair_sum_next;
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            stage_emit_reg <= emit_now;
            stage_last_reg <= last_now;
        end
        if (out_load)
        begin
            out_data_reg <= out_data_next;
            out_last_reg <= stage_last_reg;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/ibd_checker.sv
// Port-level assertions for the downsampler and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none

module ibd_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    input  wire logic                          s_axis_tready,
    input  wire logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    input  wire logic [ibd_pkg::PIXEL_W-1:0]   m_axis_tdata,
    input  wire logic                          m_axis_tlast
);

    // A result that the sink has not taken stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    // The input side only stalls when the output side is blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // A new result is loaded from the second stage, which was filled by the accepted
    // beat of the pixel that completes it; the check looks back to that beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("output beat without a matching input beat");

endmodule

bind invert_and_box_downsample_2x2 ibd_checker u_ibd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for the invert and 2x2 box downsample block.
`timescale 1ns / 1ps

// The testbench streams RGBA pixels into the block and predicts every output
// pixel on its own. The prediction is a cycle-free copy of the block's behavior:
// it tracks the next input position, the sum of the current horizontal pair and
// the line of pair sums from the last even row.
//
// Stimulus runs as a chain of named tests. They cover the reset sizes, channel
// extremes, degenerate and odd frame sizes, size and invert changes in the middle
// of a frame, out-of-range sizes, a long output stall, and a long random part.
// Registers are written only while the block is idle. A width change in the
// middle of a frame is made on an even row, or on an odd row whose remaining
// pixels only read line entries that the even row above has filled. This way
// every line entry that an odd row reads has been written before.
//
// Both stream sides idle at random. Gaps are mostly short and a few are long, and
// there are stretches with no idling at all.
module testbench;

    import ibd_pkg::*;

    localparam int MAX_W         = 4096;
    localparam int LINE_SLOTS    = MAX_W / 2;
    // Cycles to wait after the last result before touching a register. A pixel
    // that completes no block can still be in the two-stage pipe at that point.
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PIXELS = 600;

    // One predicted output beat: the averaged RGBA pixel and its end-of-frame flag.
    typedef struct packed {
        logic               frame_done;
        logic [PIXEL_W-1:0] rgba;
    } out_pixel_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [PIXEL_W-1:0]     s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [PIXEL_W-1:0]     m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;

    invert_and_box_downsample_2x2 #(
        .MAX_WIDTH(MAX_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Predicted register contents, which start at the reset values.
    logic [CFG_DATA_W-1:0] model_width  = FRAME_WIDTH_RST;
    logic [CFG_DATA_W-1:0] model_height = FRAME_HEIGHT_RST;
    logic                  model_invert = 1'b1;

    // Predicted datapath state.
    int         next_col  = 0;
    int         next_row  = 0;
    pair_t      held_pair = '0;
    pair_t      line_pairs [LINE_SLOTS];
    out_pixel_t pending_blocks [$];

    int errors       = 0;
    int pixels_sent  = 0;
    int blocks_seen  = 0;
    int reg_writes   = 0;
    bit burst_mode   = 1'b0;  // when set, the sender offers a beat on every cycle
    int hold_request = 0;     // cycles for which the sink is asked to stop taking beats

    string chan_names [NUM_CHAN] = '{"out_red", "out_green", "out_blue", "out_alpha"};

    initial begin
        forever #5 clk = ~clk;
    end

    // This is the limit for the whole run, with wide margin over the slowest legal run.
    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Works out what one accepted pixel does. The pixel may store half of a pair,
    // fill a line entry, or complete a 2x2 block and queue its average.
    function automatic void predict_pixel(input logic [PIXEL_W-1:0] px);
        int         w;
        int         h;
        int         slot;
        int         sum;
        chan_t      v;
        pair_t      cur;
        out_pixel_t blk;
        w = (model_width == 0) ? 1 : (model_width > MAX_W) ? MAX_W : int'(model_width);
        h = (model_height == 0) ? 1 :
            (model_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(model_height);
        slot = (next_col >> 1) % LINE_SLOTS;
        for (int c = 0; c < NUM_CHAN; c++) begin
            v = px[c*CHAN_W +: CHAN_W];
            if (c < RGB_CHANS && model_invert)
                v = CHAN_MAX - v;
            cur[c] = {1'b0, v};
        end
        if (next_col % 2 == 0) begin
            held_pair = cur;
        end
        else begin
            for (int c = 0; c < NUM_CHAN; c++)
                held_pair[c] = held_pair[c] + cur[c];
            if (next_row % 2 == 0) begin
                line_pairs[slot] = held_pair;
            end
            else begin
                for (int c = 0; c < NUM_CHAN; c++) begin
                    sum = line_pairs[slot][c] + held_pair[c] + ROUND_BIAS;
                    blk.rgba[c*CHAN_W +: CHAN_W] = 8'(sum >> 2);
                end
                blk.frame_done = (next_col == (w / 2) * 2 - 1) &&
                                 (next_row == (h / 2) * 2 - 1);
                pending_blocks.push_back(blk);
            end
        end
        if (next_col + 1 >= w) begin
            next_col = 0;
            next_row = (next_row + 1 >= h) ? 0 : next_row + 1;
        end
        else begin
            next_col++;
        end
    endfunction

    // Random pixel. Now and then some channels are pinned to 0 or 255.
    function automatic logic [PIXEL_W-1:0] random_pixel();
        logic [PIXEL_W-1:0] px;
        px = $urandom;
        if ($urandom_range(0, 7) == 0)
            for (int c = 0; c < NUM_CHAN; c++)
                if ($urandom_range(0, 1))
                    px[c*CHAN_W +: CHAN_W] = $urandom_range(0, 1) ? CHAN_MAX : '0;
        return px;
    endfunction

    // Offers one pixel beat, after a random gap, and waits for it to be taken.
    // Valid stays high on return, so that a back-to-back beat needs no second
    // assignment in the same step.
    task automatic send_pixel(input logic [PIXEL_W-1:0] px);
        int gap;
        int roll;
        gap  = 0;
        roll = $urandom_range(0, 99);
        if (!burst_mode) begin
            if (roll >= 98)
                gap = $urandom_range(20, 60);
            else if (roll >= 88)
                gap = $urandom_range(4, 12);
            else if (roll >= 55)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        predict_pixel(px);
        pixels_sent++;
    endtask

    // Sends random pixels until the position wraps back to the start of a frame.
    // Called at a frame start, it sends a whole frame.
    task automatic send_frame();
        do
            send_pixel(random_pixel());
        while (next_col != 0 || next_row != 0);
    endtask

    // Drops valid and waits until every predicted output pixel has arrived, then
    // waits out the settle time so that nothing is left in the pipe.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_blocks.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_FRAME_WIDTH:   model_width  = value[CFG_DATA_W-1:0];
            REG_FRAME_HEIGHT:  model_height = value[CFG_DATA_W-1:0];
            REG_INVERT_ENABLE: model_invert = value[0];
            default: ;
        endcase
        reg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_frame(input int w, input int h, input bit inv);
        settle();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_INVERT_ENABLE, inv);
    endtask

    // Reset sizes are 640x480 with inversion on. A full row and the start of the
    // next one prove the width and the default inversion. A narrower and shorter
    // frame then closes the frame early, two columns further along the odd row.
    task automatic test_reset_defaults();
        repeat (640 + 4) send_pixel(random_pixel());
        settle();
        write_reg(REG_FRAME_WIDTH, 6);
        write_reg(REG_FRAME_HEIGHT, 2);
        send_frame();
    endtask

    // All-zero and all-ones channels, mixed 0/255 blocks, and blocks whose sums
    // round both ways. The same pixels are sent with inversion off and then on.
    task automatic test_channel_extremes();
        logic [PIXEL_W-1:0] pix [12];
        pix = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0102_0301,
                32'h00FF_00FF, 32'hFF00_FF00,
                32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0201_0302,
                32'h8080_7F7F, 32'h7F7F_8080};
        for (int pass = 0; pass < 2; pass++) begin
            set_frame(6, 2, pass[0]);
            foreach (pix[i]) send_pixel(pix[i]);
        end
    endtask

    // A width or height of one gives no output at all. A size of zero acts as one.
    // With odd sizes the last column and the last row are dropped. The end flag
    // and the wrap into the next frame are checked over several frames.
    task automatic test_small_frames();
        set_frame(1, 3, 1);
        send_frame();
        set_frame(3, 1, 0);
        send_frame();
        set_frame(0, 0, 1);
        repeat (3) send_frame();
        set_frame(5, 3, 0);
        repeat (2) send_frame();
        set_frame(2, 2, 1);
        repeat (2) send_frame();
    endtask

    // Changes made while a frame is half done. Each takes effect at the next pixel.
    task automatic test_mid_frame_changes();
        set_frame(8, 6, 0);
        repeat (11) send_pixel(random_pixel());   // row 0 and three pixels of row 1
        settle();
        write_reg(REG_INVERT_ENABLE, 1);          // the two halves of one block differ
        repeat (10) send_pixel(random_pixel());   // rest of row 1, then row 2 up to column 4
        settle();
        write_reg(REG_FRAME_WIDTH, 4);            // column 5 is already past the new width
        repeat (5) send_pixel(random_pixel());    // column 5 wraps, then row 3 at width 4
        settle();
        write_reg(REG_FRAME_WIDTH, 10);
        repeat (3) send_pixel(random_pixel());
        settle();
        write_reg(REG_FRAME_WIDTH, 12);           // widen again on the same even row
        repeat (4) send_pixel(random_pixel());
        settle();
        write_reg(REG_FRAME_HEIGHT, 4);           // row 4 is already past the new height
        send_frame();
        send_frame();
    endtask

    // Sizes above the limit are clamped. Frames are started at the largest
    // register values and then cut short from inside, so any early wrap would
    // show up as a shifted block.
    task automatic test_size_limits();
        set_frame(8191, 2, 1);
        repeat (8) send_pixel(random_pixel());
        settle();
        write_reg(REG_FRAME_WIDTH, 8);            // the pixel at column 8 ends row 0
        send_frame();
        set_frame(2, 8191, 0);
        repeat (10) send_pixel(random_pixel());
        settle();
        write_reg(REG_FRAME_HEIGHT, 4);
        send_frame();
    endtask

    // The sink stops for a long stretch while the sender offers a beat on every
    // cycle. The block must fill up, stall its input, and then drain in order.
    task automatic test_backpressure();
        set_frame(16, 8, 1);
        burst_mode   = 1'b1;
        hold_request = 300;
        send_frame();
        burst_mode = 1'b0;
    endtask

    // Random sizes and inversion, mostly small frames with now and then a wide one.
    // Sometimes inversion flips part way through a frame.
    task automatic test_random_frames();
        int stop_at;
        int w;
        int h;
        int roll;
        stop_at = pixels_sent + RANDOM_PIXELS;
        while (pixels_sent < stop_at) begin
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
                w = 0;
                h = $urandom_range(0, 6);
            end
            else if (roll < 10) begin
                w = $urandom_range(60, 120);
                h = $urandom_range(1, 2);
            end
            else if (roll < 30) begin
                w = $urandom_range(13, 40);
                h = $urandom_range(1, 8);
            end
            else begin
                w = $urandom_range(1, 12);
                h = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 10);
            end
            set_frame(w, h, $urandom_range(0, 1));
            burst_mode = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 8)) send_pixel(random_pixel());
                settle();
                write_reg(REG_INVERT_ENABLE, !model_invert);
                if (next_col != 0 || next_row != 0)
                    send_frame();
            end
            repeat ($urandom_range(1, 3)) send_frame();
        end
        burst_mode = 1'b0;
    endtask

    // Output side. It takes beats with random stalls, mostly short and a few
    // long, with calm stretches where it never stalls, and a long hold when a
    // test asks for one. Each beat taken is checked against the oldest
    // predicted output pixel.
    initial begin : result_sink
        int         stall_left;
        int         calm_left;
        int         hold_left;
        int         roll;
        out_pixel_t want;
        stall_left = 0;
        calm_left  = 0;
        hold_left  = 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready) begin
                blocks_seen++;
                if (pending_blocks.size() == 0) begin
                    errors++;
                    $error("output pixel %h arrived with none expected", m_axis_tdata);
                end
                else begin
                    want = pending_blocks.pop_front();
                    for (int c = 0; c < NUM_CHAN; c++)
                        if (m_axis_tdata[c*CHAN_W +: CHAN_W] !== want.rgba[c*CHAN_W +: CHAN_W])
                        begin
                            errors++;
                            $error("%s mismatch: expected %0d, got %0d", chan_names[c],
                                   want.rgba[c*CHAN_W +: CHAN_W],
                                   m_axis_tdata[c*CHAN_W +: CHAN_W]);
                        end
                    if (m_axis_tlast !== want.frame_done) begin
                        errors++;
                        $error("frame_done mismatch: expected %0d, got %0d",
                               want.frame_done, m_axis_tlast);
                    end
                end
            end
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else begin
                m_axis_tready <= 1'b1;
                if (calm_left > 0) begin
                    calm_left--;
                end
                else begin
                    roll = $urandom_range(0, 99);
                    if (roll < 3)
                        calm_left = $urandom_range(20, 200);
                    else if (roll < 25)
                        stall_left = $urandom_range(1, 3);
                    else if (roll < 28)
                        stall_left = $urandom_range(10, 40);
                end
            end
        end
    end

    initial begin : test_sequence
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_channel_extremes();
        test_small_frames();
        test_mid_frame_changes();
        test_size_limits();
        test_backpressure();
        test_random_frames();

        // Let the last averages drain, but only for a bounded time.
        s_axis_tvalid <= 1'b0;
        for (int i = 0; i < 1000 && pending_blocks.size() != 0; i++) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_blocks.size() != 0) begin
            errors++;
            $error("%0d predicted output pixels never arrived", pending_blocks.size());
        end

        $display("Streamed %0d pixels and checked %0d averaged pixels across %0d register",
                 pixels_sent, blocks_seen, reg_writes);
        $display("writes: widths 0 to 8191, heights 0 to 8191, inversion on and off.");
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/ibd_pkg.sv
rtl/core/invert_and_box_downsample_2x2.sv
rtl/core/ibd_checker.sv
verif/testbench.sv
